/* src/adl_pkg.sv */
// Adler-32 checksum package: widths, constants and the lane-to-accumulator item type.
// Shared by every module of the adler32_checksum block; depends on nothing.
package adl_pkg;

  localparam int LANES   = 8;
  localparam int BYTE_W  = 8;
  localparam int DATA_W  = LANES * BYTE_W;
  localparam int CNT_W   = 4;
  localparam int IDX_W   = $clog2(LANES) > 0 ? $clog2(LANES) : 1;
  localparam int SUM_W   = 11;
  localparam int WSUM_W  = 14;
  localparam int LBYTE_W = 12;
  localparam int LEN_W   = 17;

  localparam logic [16:0]      ADLER_MOD  = 17'd65521;
  localparam logic [LEN_W-1:0] LENGTH_CAP = 17'd65536;
  localparam logic [15:0]      MAX_LEN_RST = 16'hFFFF;
  localparam logic [CNT_W-1:0] LANES_CNT  = CNT_W'(LANES);

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [WSUM_W-1:0] wsum;
    logic [CNT_W-1:0]  cnt;
    logic              first;
    logic              last;
  } item_t;

endpackage

/* src/adl_lane.sv */
// One byte lane: masks its byte by the valid count and weights it for sum b.
// Depends on adl_pkg.
module adl_lane (
  input  logic [adl_pkg::BYTE_W-1:0]  lane_byte,
  input  logic [adl_pkg::IDX_W-1:0]   lane_idx,
  input  logic [adl_pkg::CNT_W-1:0]   cnt,
  output logic [adl_pkg::BYTE_W-1:0]  byte_out,
  output logic [adl_pkg::LBYTE_W-1:0] weighted
);
  import adl_pkg::*;

  logic             in_use;
  logic [CNT_W-1:0] weight;

  assign in_use   = CNT_W'(lane_idx) < cnt;
  assign weight   = cnt - CNT_W'(lane_idx);
  assign byte_out = in_use ? lane_byte : '0;
  assign weighted = in_use ? LBYTE_W'(lane_byte) * LBYTE_W'(weight) : '0;

endmodule

/* src/adl_merge.sv */
// Lane array and merging stage: clamps the count, runs the lanes, sums their
// results and registers one item summary. Depends on adl_pkg and adl_lane.
module adl_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic                        in_take,
  input  logic [adl_pkg::DATA_W-1:0]  data_bytes,
  input  logic [adl_pkg::CNT_W-1:0]   byte_count,
  input  logic                        first,
  input  logic                        last,
  output logic                        item_valid,
  output adl_pkg::item_t              item
);
  import adl_pkg::*;

  logic [CNT_W-1:0]   cnt;
  logic [BYTE_W-1:0]  lane_bytes [LANES];
  logic [LBYTE_W-1:0] lane_wts   [LANES];
  logic [SUM_W-1:0]   sum;
  logic [WSUM_W-1:0]  wsum;
  item_t              item_r, item_nxt;
  logic               valid_r, valid_nxt;

  assign cnt = (byte_count > LANES_CNT) ? LANES_CNT : byte_count;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    adl_lane u_lane (
      .lane_byte (data_bytes[g*BYTE_W +: BYTE_W]),
      .lane_idx  (IDX_W'(g)),
      .cnt       (cnt),
      .byte_out  (lane_bytes[g]),
      .weighted  (lane_wts[g])
    );
  end

  always_comb begin
    sum  = '0;
    wsum = '0;
    for (int i = 0; i < LANES; i++) begin
      sum  = sum + SUM_W'(lane_bytes[i]);
      wsum = wsum + WSUM_W'(lane_wts[i]);
    end
  end

  always_comb begin
    item_nxt  = item_r;
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt      = in_take;
      item_nxt.sum   = sum;
      item_nxt.wsum  = wsum;
      item_nxt.cnt   = cnt;
      item_nxt.first = first;
      item_nxt.last  = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* src/adl_accum.sv */
// Running Adler-32 sums and length, modulo reduction and the result register.
// Depends on adl_pkg; fed by adl_merge.
module adl_accum (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  input  adl_pkg::item_t item,
  input  logic [15:0]    max_length,
  input  logic           out_ready,
  output logic           item_take,
  output logic           out_valid,
  output logic [31:0]    out_checksum,
  output logic           out_too_long
);
  import adl_pkg::*;

  logic [15:0]      a_r, a_nxt, b_r, b_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ov_r, ov_nxt;
  logic [31:0]      ck_r, ck_nxt;
  logic             tl_r, tl_nxt;

  logic [15:0]      a_base, b_base;
  logic [LEN_W-1:0] len_base, len_sum, len_new;
  logic [16:0]      a_sum, a_new;
  logic [19:0]      b_x;
  logic [16:0]      b_fold, b_new;
  logic             too_long;

  assign item_take = item_valid && (!item.last || !ov_r || out_ready);

  assign a_base   = item.first ? 16'd1 : a_r;
  assign b_base   = item.first ? 16'd0 : b_r;
  assign len_base = item.first ? '0 : len_r;

  assign a_sum  = {1'b0, a_base} + 17'(item.sum);
  assign a_new  = (a_sum >= ADLER_MOD) ? a_sum - ADLER_MOD : a_sum;

  // 2^16 is 15 modulo 65521: fold the high bits back in
  assign b_x    = 20'(b_base) + 20'(a_base) * 20'(item.cnt) + 20'(item.wsum);
  assign b_fold = 17'(b_x[15:0]) + 17'(b_x[19:16]) * 17'd15;
  assign b_new  = (b_fold >= ADLER_MOD) ? b_fold - ADLER_MOD : b_fold;

  assign len_sum  = len_base + LEN_W'(item.cnt);
  assign len_new  = (len_sum > LENGTH_CAP) ? LENGTH_CAP : len_sum;
  assign too_long = len_new > LEN_W'(max_length);

  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    len_nxt = len_r;
    ov_nxt  = ov_r;
    ck_nxt  = ck_r;
    tl_nxt  = tl_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    if (item_take) begin
      if (item.last) begin
        a_nxt   = 16'd1;
        b_nxt   = 16'd0;
        len_nxt = '0;
        ov_nxt  = 1'b1;
        tl_nxt  = too_long;
        ck_nxt  = too_long ? 32'd0 : {b_new[15:0], a_new[15:0]};
      end else begin
        a_nxt   = a_new[15:0];
        b_nxt   = b_new[15:0];
        len_nxt = len_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r   <= 16'd1;
      b_r   <= 16'd0;
      len_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      len_r <= len_nxt;
      ov_r  <= ov_nxt;
    end
    ck_r <= ck_nxt;
    tl_r <= tl_nxt;
  end

  assign out_valid    = ov_r;
  assign out_checksum = ck_r;
  assign out_too_long = tl_r;

endmodule

/* src/adler32_checksum.sv */
// Adler-32 checksum top level: eight byte lanes, a merging stage and the
// modulo accumulator with its result register. Depends on adl_pkg, adl_merge, adl_accum.
//
//   channel | signals                                             | dir
//   in      | in_valid/in_ready, data_bytes, byte_count, first, last | input
//   out     | out_valid/out_ready, checksum, too_long              | output
//   cfg     | cfg_wr_en, cfg_wr_data (max_length)                  | input
//
// One transaction of up to eight bytes per cycle while in_ready is high. The lane
// stage registers a per-transaction sum and weighted sum; the accumulator folds
// both into a and b and registers a result once the last transaction is taken.
// Reset: synchronous, active low; sums return to a=1, b=0, max_length to 65535.
// A waiting result holds a following last transaction in the lane stage, which
// stalls the input until the result is taken.
module adler32_checksum (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [adl_pkg::DATA_W-1:0] in_data_bytes,
  input  logic [adl_pkg::CNT_W-1:0]  in_byte_count,
  input  logic                       in_first,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [31:0]                out_checksum,
  output logic                       out_too_long,
  input  logic                       cfg_wr_en,
  input  logic [15:0]                cfg_wr_data
);
  import adl_pkg::*;

  logic        item_valid, item_take, advance;
  item_t       item;
  logic [15:0] max_len_r, max_len_nxt;

  assign advance  = !item_valid || item_take;
  assign in_ready = advance;

  assign max_len_nxt = cfg_wr_en ? cfg_wr_data : max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  adl_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .in_take    (in_valid),
    .data_bytes (in_data_bytes),
    .byte_count (in_byte_count),
    .first      (in_first),
    .last       (in_last),
    .item_valid (item_valid),
    .item       (item)
  );

  adl_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item         (item),
    .max_length   (max_len_r),
    .out_ready    (out_ready),
    .item_take    (item_take),
    .out_valid    (out_valid),
    .out_checksum (out_checksum),
    .out_too_long (out_too_long)
  );

  a_too_long_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_long |-> out_checksum == 32'd0)
    else $error("too_long result with nonzero checksum");

  a_sums_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_too_long |->
      (17'(out_checksum[15:0]) < ADLER_MOD) && (17'(out_checksum[31:16]) < ADLER_MOD))
    else $error("checksum half not reduced modulo 65521");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(item_valid && item_take && item.last))
    else $error("result raised without a last transaction");

  a_stall_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> item_valid && item.last && out_valid && !out_ready)
    else $error("input stalled without a blocked last transaction");

endmodule

/* dv/tb_adler32_checksum.sv */
`timescale 1ns / 1ps
// Self-checking testbench for adler32_checksum: directed table, random messages, three idle patterns.
// Depends on adl_pkg and the adler32_checksum RTL; the checksum predictor is kept locally.
module tb_adler32_checksum;
  import adl_pkg::*;

  typedef struct packed {
    logic [31:0] checksum;
    logic        too_long;
  } result_t;

  typedef struct packed {
    bit          is_cfg;
    logic [15:0] cfg_val;
    logic [63:0] data;
    logic [3:0]  count;
    bit          first;
    bit          last;
    bit          typed;
    logic [31:0] exp_sum;
    bit          exp_long;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [DATA_W-1:0] in_data_bytes = '0;
  logic [CNT_W-1:0]  in_byte_count = '0;
  logic              in_first = 1'b0;
  logic              in_last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [31:0]       out_checksum;
  logic              out_too_long;
  logic              cfg_wr_en = 1'b0;
  logic [15:0]       cfg_wr_data = '0;

  logic [15:0] run_a;
  logic [15:0] run_b;
  logic [16:0] run_len;
  logic [15:0] max_len_cfg;

  result_t  checksum_q[$];
  dir_row_t dir_rows[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int sums_checked = 0;
  int long_flags = 0;
  int cfg_writes = 0;

  adler32_checksum dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_bytes (in_data_bytes),
    .in_byte_count (in_byte_count),
    .in_first      (in_first),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_checksum  (out_checksum),
    .out_too_long  (out_too_long),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void restart_sums();
    run_a = 16'd1;
    run_b = 16'd0;
    run_len = '0;
  endfunction

  function automatic void adler_absorb(input logic [63:0] d, input logic [3:0] c,
                                       input bit f, input bit l,
                                       output bit has_result, output result_t r);
    logic [3:0]  n;
    logic [16:0] t;
    if (f) restart_sums();
    n = (c > LANES_CNT) ? LANES_CNT : c;
    for (int k = 0; k < n; k++) begin
      t = {1'b0, run_a} + {9'd0, d[8*k +: 8]};
      if (t >= ADLER_MOD) t = t - ADLER_MOD;
      run_a = t[15:0];
      t = {1'b0, run_b} + {1'b0, run_a};
      if (t >= ADLER_MOD) t = t - ADLER_MOD;
      run_b = t[15:0];
    end
    run_len = run_len + {13'd0, n};
    if (run_len > LENGTH_CAP) run_len = LENGTH_CAP;
    has_result = l;
    r = '0;
    if (l) begin
      if (run_len > {1'b0, max_len_cfg}) begin
        r.checksum = '0;
        r.too_long = 1'b1;
      end else begin
        r.checksum = {run_b, run_a};
        r.too_long = 1'b0;
      end
      restart_sums();
    end
  endfunction

  function automatic void dir_row(input bit is_cfg, input logic [15:0] v,
                                  input logic [63:0] d, input logic [3:0] c,
                                  input bit f, input bit l, input bit typed,
                                  input logic [31:0] es, input bit el);
    dir_row_t r;
    r = '{is_cfg, v, d, c, f, l, typed, es, el};
    dir_rows.push_back(r);
  endfunction

  task automatic send_item(input logic [63:0] d, input logic [3:0] c, input bit f,
                           input bit l, input bit typed, input logic [31:0] es,
                           input bit el);
    bit      has;
    result_t pr;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_bytes <= d;
    in_byte_count <= c;
    in_first      <= f;
    in_last       <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    adler_absorb(d, c, f, l, has, pr);
    if (has) begin
      if (typed) begin
        pr.checksum = es;
        pr.too_long = el;
      end
      checksum_q.push_back(pr);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (checksum_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_max_length(input logic [15:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_len_cfg = v;
    cfg_writes++;
  endtask

  task automatic send_message();
    int          n;
    bit          f;
    logic [3:0]  c;
    n = ($urandom_range(7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      f = (i == 0) ? ($urandom_range(99) < 85) : ($urandom_range(99) < 3);
      c = ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      send_item({$urandom, $urandom}, c, f, i == n - 1, 1'b0, '0, 1'b0);
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (checksum_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: checksum=%h too_long=%b", out_checksum, out_too_long);
      end else begin
        want = checksum_q.pop_front();
        sums_checked++;
        if (want.too_long) long_flags++;
        if (out_checksum !== want.checksum || out_too_long !== want.too_long) begin
          errors++;
          if (errors <= 10)
            $display("result %0d: expected checksum=%h too_long=%b, got checksum=%h too_long=%b",
                     sums_checked, want.checksum, want.too_long, out_checksum, out_too_long);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    dir_rows.delete();
    max_len_cfg = MAX_LEN_RST;
    restart_sums();
    // empty message, single byte, full lanes, oversized counts
    dir_row(0, 0, 64'h0, 4'd0, 1, 1, 1, 32'h0000_0001, 0);
    dir_row(0, 0, 64'hFF, 4'd1, 1, 1, 0, '0, 0);
    dir_row(0, 0, '1, 4'd8, 1, 1, 0, '0, 0);
    dir_row(0, 0, '1, 4'd15, 1, 1, 0, '0, 0);
    dir_row(0, 0, 64'h0123_4567_89AB_CDEF, 4'd9, 0, 1, 0, '0, 0);
    // empty items inside and at the end, restart mid-message
    dir_row(0, 0, 64'h0, 4'd8, 1, 0, 0, '0, 0);
    dir_row(0, 0, '1, 4'd0, 0, 0, 0, '0, 0);
    dir_row(0, 0, 64'hDEAD_BEEF_CAFE_F00D, 4'd3, 0, 1, 0, '0, 0);
    dir_row(0, 0, 64'hA5A5_5A5A_A5A5_5A5A, 4'd8, 1, 0, 0, '0, 0);
    dir_row(0, 0, 64'h1122_3344_5566_7788, 4'd5, 1, 0, 0, '0, 0);
    dir_row(0, 0, '1, 4'd0, 0, 1, 0, '0, 0);
    // length limit at zero and at a small boundary
    dir_row(1, 16'd0, '0, '0, 0, 0, 0, '0, 0);
    dir_row(0, 0, 64'hFF, 4'd1, 1, 1, 1, 32'h0, 1);
    dir_row(0, 0, 64'h0, 4'd0, 1, 1, 1, 32'h0000_0001, 0);
    dir_row(1, 16'd4, '0, '0, 0, 0, 0, '0, 0);
    dir_row(0, 0, 64'h0403_0201, 4'd4, 1, 1, 0, '0, 0);
    dir_row(0, 0, 64'h0003_0201, 4'd3, 1, 0, 0, '0, 0);
    dir_row(0, 0, 64'hFFEE, 4'd2, 0, 1, 1, 32'h0, 1);
    dir_row(1, 16'hFFFF, '0, '0, 0, 0, 0, '0, 0);
    dir_row(0, 0, '1, 4'd8, 1, 0, 0, '0, 0);
    dir_row(0, 0, '1, 4'd8, 0, 1, 0, '0, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        set_max_length(dir_rows[i].cfg_val);
      else
        send_item(dir_rows[i].data, dir_rows[i].count, dir_rows[i].first,
                  dir_rows[i].last, dir_rows[i].typed, dir_rows[i].exp_sum,
                  dir_rows[i].exp_long);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        case (seg)
          0: set_max_length(16'd0);
          1: set_max_length(16'($urandom_range(4, 40)));
          2: set_max_length(MAX_LEN_RST);
          default: begin
            if (phase == 2) set_max_length(16'($urandom_range(0, 65535)));
            else set_max_length(16'($urandom_range(8, 64)));
          end
        endcase
        begin : segment
          int target;
          target = items_sent + 75;
          while (items_sent < target) send_message();
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    errors += checksum_q.size();
    $display("Sent %0d transactions, checked %0d checksums (%0d flagged too long).",
             items_sent, sums_checked, long_flags);
    $display("Wrote max_length %0d times, from 0 up to 65535, under three idle patterns.",
             cfg_writes);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
src/adl_pkg.sv
src/adl_lane.sv
src/adl_merge.sv
src/adl_accum.sv
src/adler32_checksum.sv
dv/tb_adler32_checksum.sv
